>>> sv/sacl_pkg.sv
// Shared constants, types and address helpers for the set-associative cache.
package sacl_pkg;

	// Geometry; NUM_SETS, NUM_WAYS and LINE_BYTES are powers of two.
	localparam int NUM_SETS   = 4;
	localparam int NUM_WAYS   = 2;
	localparam int LINE_BYTES = 32;

	localparam int ADDR_W = 32;
	localparam int WORD_W = 32;
	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int SET_W  = $clog2(NUM_SETS);
	localparam int SET_IW = (SET_W > 0) ? SET_W : 1;
	localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int RANK_W = WAY_W;

	localparam logic [WORD_W-1:0] FILL_WORD = 32'hffff_ffff;

	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	typedef logic [TAG_W-1:0]  tag_t;
	typedef logic [SET_IW-1:0] set_t;
	typedef logic [WAY_W-1:0]  way_t;
	typedef logic [RANK_W-1:0] rank_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef rank_t [NUM_WAYS-1:0] rank_vec_t;
	typedef logic  [NUM_WAYS-1:0] valid_vec_t;

	// One memory row holds a whole set: every way's tag and word.
	typedef struct packed {
		tag_t  [NUM_WAYS-1:0] tags;
		word_t [NUM_WAYS-1:0] words;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	// Result of the tag compare and replacement choice.
	typedef struct packed {
		logic      hit;
		way_t      way;
		rank_vec_t ranks;
	} look_t;

	function automatic set_t addr_set(input logic [ADDR_W-1:0] addr);
		return set_t'((addr >> OFF_W) & ADDR_W'(NUM_SETS - 1));
	endfunction

	function automatic tag_t line_tag(input logic [ADDR_W-1:0] addr);
		return tag_t'(addr >> (OFF_W + SET_W));
	endfunction

endpackage

>>> sv/sacl_req_if.sv
// Request channel: access kind, address and write word.
interface sacl_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [31:0] address;
	logic [31:0] write_data;

	modport source (output valid, req_type, address, write_data, input ready);
	modport sink   (input valid, req_type, address, write_data, output ready);
endinterface

>>> sv/sacl_rsp_if.sv
// Response channel: read word, hit flag, way and completion code.
interface sacl_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_data;
	logic        hit;
	logic        way_used;
	logic        done_kind;

	modport source (output valid, read_data, hit, way_used, done_kind, input ready);
	modport sink   (input valid, read_data, hit, way_used, done_kind, output ready);
endinterface

>>> sv/set_assoc_cache_lru.sv
// A transaction accepted in the idle state is looked up in the lookup state, and no
// new request is taken until the response is registered; the set row is read from
//   the tag/data RAM in the accept cycle and written back when the lookup finishes.
// The lookup cycle stalls while a previous response is still held unaccepted.
// Reset (arst_n low, asynchronous) clears the FSM, response valid, valid bits and
//   LRU ranks; the tag/data RAM is not cleared, and invalid lines never produce a hit.
module set_assoc_cache_lru (
	input logic      clk,
	input logic      arst_n,
	sacl_req_if.sink   req,
	sacl_rsp_if.source rsp
);
	import sacl_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

	state_t state_q;

	// Request held for the lookup cycle.
	logic  req_type_s1;
	tag_t  tag_s1;
	set_t  set_s1;
	word_t wdata_s1;

	// Per-set valid bits and ranks live in flops so reset clears them at once.
	valid_vec_t valid_q [NUM_SETS];
	rank_vec_t  rank_q  [NUM_SETS];

	row_t  row_rd;
	row_t  row_wr;
	look_t look;
	logic  accept;
	logic  finish;
	word_t rdata_nx;

	// Response register.
	logic  rsp_valid_q;
	word_t rsp_data_q;
	logic  rsp_hit_q;
	logic  rsp_way_q;
	logic  rsp_kind_q;

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	// Lookup completes once the response register is free or being drained.
	assign finish    = (state_q == ST_LOOK) && (!rsp_valid_q || rsp.ready);

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_ram (
		.clk   (clk),
		.we    (finish),
		.waddr (set_s1),
		.wdata (row_wr),
		.re    (accept),
		.raddr (addr_set(req.address)),
		.rdata (row_rd)
	);

	sacl_lookup u_lookup (
		.tag   (tag_s1),
		.row   (row_rd),
		.valid (valid_q[set_s1]),
		.ranks (rank_q[set_s1]),
		.res   (look)
	);

	// Modify the row: the chosen way takes the tag and its new word.
	// Read hit keeps the stored word, read miss fills, write stores its data.
	always_comb begin
		row_wr = row_rd;
		row_wr.tags[look.way] = tag_s1;
		if (req_type_s1 == REQ_WRITE) begin
			row_wr.words[look.way] = wdata_s1;
		end else if (!look.hit) begin
			row_wr.words[look.way] = FILL_WORD;
		end
		if (req_type_s1 == REQ_WRITE) begin
			rdata_nx = '0;
		end else if (look.hit) begin
			rdata_nx = row_rd.words[look.way];
		end else begin
			rdata_nx = FILL_WORD;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req.req_type;
			tag_s1      <= line_tag(req.address);
			set_s1      <= addr_set(req.address);
			wdata_s1    <= req.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SETS; s++) begin
				valid_q[s] <= '0;
				rank_q[s]  <= '0;
			end
		end else if (finish) begin
			valid_q[set_s1][look.way] <= 1'b1;
			rank_q[set_s1]            <= look.ranks;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_data_q <= rdata_nx;
			rsp_hit_q  <= look.hit;
			rsp_way_q  <= look.way[0];
			rsp_kind_q <= req_type_s1;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = rsp_data_q;
	assign rsp.hit       = rsp_hit_q;
	assign rsp.way_used  = rsp_way_q;
	assign rsp.done_kind = rsp_kind_q;

	// An accepted transaction blocks the next one for the lookup cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request accepted while lookup pending");

	// Every completed lookup produces a response in the next cycle.
	a_finish_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> rsp.valid)
		else $error("lookup finished without response");

	// Writes return zero; read misses return the fill word.
	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.done_kind == REQ_WRITE |-> rsp.read_data == '0)
		else $error("write response carries data");

	a_miss_fill: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.hit && rsp.done_kind == REQ_READ |-> rsp.read_data == FILL_WORD)
		else $error("read miss did not return fill word");

	// The accessed way always ends up valid and most recent.
	a_touch: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> valid_q[$past(set_s1)][$past(look.way)]
			&& rank_q[$past(set_s1)][$past(look.way)] == rank_t'(NUM_WAYS - 1))
		else $error("accessed way not marked valid and most recent");

endmodule

>>> sv/sacl_ram.sv
// Generic single-port-write, registered-read RAM.
module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/sacl_lookup.sv
// Tag compare across ways, victim choice and LRU rank update for one set.
module sacl_lookup (
	input  sacl_pkg::tag_t       tag,
	input  sacl_pkg::row_t       row,
	input  sacl_pkg::valid_vec_t valid,
	input  sacl_pkg::rank_vec_t  ranks,
	output sacl_pkg::look_t      res
);
	import sacl_pkg::*;

	logic  hit;
	way_t  hit_way;
	logic  any_inv;
	way_t  inv_way;
	way_t  lru_way;
	way_t  way;
	rank_t old_rank;

	// Lowest matching valid way, lowest invalid way, and the rank-0 way.
	// Once every way is valid the ranks form a permutation, so rank 0 is unique.
	always_comb begin
		hit     = 1'b0;
		hit_way = '0;
		any_inv = 1'b0;
		inv_way = '0;
		lru_way = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (valid[w] && row.tags[w] == tag) begin
				hit     = 1'b1;
				hit_way = way_t'(w);
			end
			if (!valid[w]) begin
				any_inv = 1'b1;
				inv_way = way_t'(w);
			end
			if (ranks[w] == '0) begin
				lru_way = way_t'(w);
			end
		end
	end

	always_comb begin
		if (hit) begin
			way = hit_way;
		end else if (any_inv) begin
			way = inv_way;
		end else begin
			way = lru_way;
		end
		old_rank = ranks[way];
	end

	always_comb begin
		res.hit = hit;
		res.way = way;
		for (int w = 0; w < NUM_WAYS; w++) begin
			if (way_t'(w) == way) begin
				res.ranks[w] = rank_t'(NUM_WAYS - 1);
			end else if (ranks[w] > old_rank) begin
				res.ranks[w] = ranks[w] - rank_t'(1);
			end else begin
				res.ranks[w] = ranks[w];
			end
		end
	end

endmodule

>>> tb/set_assoc_cache_lru_tb.sv
// Testbench for set_assoc_cache_lru: directed and random accesses checked against an LRU cache predictor.
`timescale 1ns / 1ps

module set_assoc_cache_lru_tb;
	import sacl_pkg::*;

	// Give up well past the slowest legal run: ~1400 transactions, each at worst slowed
	// by a sender gap, the block's idle and lookup states and a receiver stall.
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_COUNT = 1350;
	// The final stretch runs with no idling on either side.
	localparam int CALM_COUNT = 150;
	// Tags kept per set, one more than there are ways, so misses evict.
	localparam int POOL_DEPTH = NUM_WAYS + 1;
	// The tail wait leaves room for any stray response after the predictor is drained.
	localparam int TAIL_CYCLES = 20;

	typedef struct packed {
		logic  req_type;
		word_t address;
		word_t write_data;
	} access_t;

	typedef struct packed {
		word_t read_data;
		logic  hit;
		logic  way_used;
		logic  done_kind;
	} resp_t;

	// Cache predictor plus the queue of responses it still owes.
	// Tags and words are only read from lines marked live, as in the block.
	class lru_cache_model;
		tag_t  tags  [NUM_SETS][NUM_WAYS];
		word_t words [NUM_SETS][NUM_WAYS];
		bit    live  [NUM_SETS][NUM_WAYS];
		rank_t age   [NUM_SETS][NUM_WAYS];
		resp_t due[$];
		int    mismatches;

		function new();
			foreach (live[s, w]) begin
				live[s][w] = 1'b0;
				age[s][w]  = '0;
			end
			mismatches = 0;
		endfunction

		// Called for every accepted request transaction.
		function void note_access(access_t a);
			int unsigned line;
			int unsigned s;
			int unsigned way;
			tag_t        t;
			bit          found;
			rank_t       old;
			resp_t       r;

			line  = a.address / LINE_BYTES;
			s     = line % NUM_SETS;
			t     = tag_t'(line / NUM_SETS);
			found = 1'b0;
			way   = 0;
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (!found && live[s][w] && tags[s][w] == t) begin
					found = 1'b1;
					way   = w;
				end
			end

			r.read_data = '0;
			if (!found) begin
				// Victim: first empty way, else least recent with the low way winning ties.
				way = NUM_WAYS;
				for (int w = 0; w < NUM_WAYS; w++)
					if (way == NUM_WAYS && !live[s][w])
						way = w;
				if (way == NUM_WAYS) begin
					way = 0;
					for (int w = 1; w < NUM_WAYS; w++)
						if (age[s][w] < age[s][way])
							way = w;
				end
				tags[s][way] = t;
				live[s][way] = 1'b1;
				if (a.req_type == REQ_WRITE) begin
					words[s][way] = a.write_data;
				end else begin
					words[s][way] = FILL_WORD;
					r.read_data   = FILL_WORD;
				end
			end else if (a.req_type == REQ_WRITE) begin
				words[s][way] = a.write_data;
			end else begin
				r.read_data = words[s][way];
			end

			// The touched way becomes most recent; ways above its old rank slide down.
			old = age[s][way];
			for (int w = 0; w < NUM_WAYS; w++)
				if (w != way && age[s][w] > old)
					age[s][w]--;
			age[s][way] = rank_t'(NUM_WAYS - 1);

			r.hit       = found;
			r.way_used  = way[0];
			r.done_kind = a.req_type;
			due.push_back(r);
		endfunction

		// Called for every accepted response transaction.
		function void check_response(resp_t got);
			resp_t exp;

			if (due.size() == 0) begin
				$error("response with no access outstanding: read_data %h hit %b way %b",
					got.read_data, got.hit, got.way_used);
				mismatches++;
				return;
			end
			exp = due.pop_front();
			if (got.read_data !== exp.read_data) begin
				$error("read_data: expected %h, got %h", exp.read_data, got.read_data);
				mismatches++;
			end
			if (got.hit !== exp.hit) begin
				$error("hit: expected %b, got %b", exp.hit, got.hit);
				mismatches++;
			end
			if (got.way_used !== exp.way_used) begin
				$error("way_used: expected %b, got %b", exp.way_used, got.way_used);
				mismatches++;
			end
			if (got.done_kind !== exp.done_kind) begin
				$error("done_kind: expected %b, got %b", exp.done_kind, got.done_kind);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	bit   calm;     // no idling on either side
	bit   gaps_on;  // sender idles in this stretch
	tag_t tag_pool [NUM_SETS][POOL_DEPTH];

	lru_cache_model lru;

	sacl_req_if req();
	sacl_rsp_if rsp();

	set_assoc_cache_lru i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("set_assoc_cache_lru verification failed");
			$finish;
		end
	end

	// Response monitor: every accepted transaction goes to the predictor's check.
	// A response can never belong to a request accepted at the same edge, so
	// the order against note_access within one step does not matter.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready)
			lru.check_response('{read_data: rsp.read_data, hit: rsp.hit,
				way_used: rsp.way_used, done_kind: rsp.done_kind});
	end

	// Receiver back-pressure: ready-high stretches of random length, each
	// maybe followed by a stall. Held high once the run is calm.
	initial begin
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rsp.ready <= 1'b1;
			repeat ($urandom_range(0, 30)) @(negedge clk);
			if (!calm && $urandom_range(0, 2) != 0) begin
				@(negedge clk);
				rsp.ready <= 1'b0;
				repeat ($urandom_range(0, 8)) @(negedge clk);
			end
		end
	end

	// Present one request from the falling edge, hold it until accepted, then
	// maybe idle the sender. Valid is only lowered for a gap.
	task automatic send_access(input access_t a);
		int gap;

		@(negedge clk);
		req.valid      <= 1'b1;
		req.req_type   <= a.req_type;
		req.address    <= a.address;
		req.write_data <= a.write_data;
		do
			@(posedge clk);
		while (!req.ready);
		lru.note_access(a);
		if (!calm && gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			// Junk payload while idle; the block must ignore it.
			req.valid      <= 1'b0;
			req.req_type   <= 1'($urandom_range(0, 1));
			req.address    <= $urandom();
			req.write_data <= $urandom();
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Mostly accesses that cycle a small tag set through each cache set, so
	// hits, fills and LRU evictions all come often; the rest is any address.
	function automatic access_t random_access();
		access_t     a;
		int unsigned s;
		int unsigned k;
		int unsigned pick;

		a.req_type = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 8) begin
			a.address = $urandom();
		end else begin
			s = $urandom_range(0, NUM_SETS - 1);
			k = $urandom_range(0, POOL_DEPTH - 1);
			if ($urandom_range(0, 39) == 0)
				tag_pool[s][k] = tag_t'($urandom());
			a.address = (word_t'(tag_pool[s][k]) << (OFF_W + SET_W))
				| word_t'(s * LINE_BYTES) | word_t'($urandom_range(0, LINE_BYTES - 1));
		end
		pick = $urandom_range(0, 9);
		if (pick == 0)
			a.write_data = '0;
		else if (pick == 1)
			a.write_data = '1;
		else
			a.write_data = $urandom();
		return a;
	endfunction

	initial begin
		access_t a;

		arst_n         = 1'b0;
		cycle_count    = 0;
		calm           = 1'b0;
		gaps_on        = 1'b1;
		req.valid      = 1'b0;
		req.req_type   = REQ_READ;
		req.address    = '0;
		req.write_data = '0;
		lru            = new();
		foreach (tag_pool[s, k])
			tag_pool[s][k] = tag_t'($urandom());
		// Extremes of the tag field sit in the pool from the start.
		tag_pool[0][0]            = '0;
		tag_pool[NUM_SETS - 1][0] = '1;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: set 0 first fills its two empty ways, then evicts by LRU.
		send_access('{REQ_READ,  32'h0000_0000, 32'h0000_0000}); // read miss, fill way 0
		send_access('{REQ_READ,  32'h0000_0000, 32'h1234_5678}); // read hit returns fill word
		send_access('{REQ_WRITE, 32'h0000_001f, 32'h0000_0000}); // write hit, other offset
		send_access('{REQ_READ,  32'h0000_0004, 32'hffff_ffff}); // reads back zero
		send_access('{REQ_WRITE, 32'h0000_0080, 32'hffff_ffff}); // write miss into empty way 1
		send_access('{REQ_READ,  32'h0000_0080, 32'h0000_0000}); // read hit way 1
		send_access('{REQ_WRITE, 32'h0000_0100, 32'h1234_5678}); // miss, way 0 least recent
		send_access('{REQ_READ,  32'h0000_0000, 32'h0000_0000}); // old tag gone, evicts way 1
		send_access('{REQ_READ,  32'h0000_0100, 32'h0000_0000}); // still resident
		send_access('{REQ_WRITE, 32'hffff_ffff, 32'hffff_ffff}); // all-ones address, set 3
		send_access('{REQ_READ,  32'hffff_ffe0, 32'h0000_0000}); // hit on same line
		send_access('{REQ_WRITE, 32'h7fff_ffe0, 32'h0000_0000}); // set 3, way 1
		send_access('{REQ_READ,  32'hffff_ffff, 32'h0000_0000}); // hit, way 0 most recent
		send_access('{REQ_WRITE, 32'h0000_0060, 32'ha5a5_a5a5}); // evicts way 1
		send_access('{REQ_READ,  32'h7fff_ffe0, 32'h0000_0000}); // miss again, evicts way 0
		send_access('{REQ_READ,  32'h0000_0060, 32'h0000_0000}); // hit, written word
		send_access('{REQ_WRITE, 32'h0000_0020, 32'h0000_0000}); // set 1 write miss
		send_access('{REQ_READ,  32'h0000_0040, 32'h0000_0000}); // set 2 read miss
		send_access('{REQ_READ,  32'hdead_beef, 32'h0000_0000}); // set 3 miss
		send_access('{REQ_WRITE, 32'hdead_beef, 32'h5a5a_5a5a}); // write hit same address
		send_access('{REQ_READ,  32'hdead_bee0, 32'hffff_ffff}); // read it back

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i % 50 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (i == RANDOM_COUNT - CALM_COUNT)
				calm = 1'b1;
			a = random_access();
			send_access(a);
		end
		@(negedge clk);
		req.valid <= 1'b0;

		// Drain, then give any stray response time to show up.
		while (lru.due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (lru.mismatches == 0)
			$display("set_assoc_cache_lru verification clean");
		else
			$display("set_assoc_cache_lru verification failed");
		$finish;
	end

endmodule

>>> set_assoc_cache_lru.f
sv/sacl_pkg.sv
sv/sacl_req_if.sv
sv/sacl_rsp_if.sv
sv/sacl_ram.sv
sv/sacl_lookup.sv
sv/set_assoc_cache_lru.sv
tb/set_assoc_cache_lru_tb.sv
